// ===== hw/rtl/sdaf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdaf_pkg
// Shared types, register map, character codes and a helper function for the
// signed decimal ASCII formatter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

  // Configuration register map
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FORMAT_MODE = 3'd0;

  // Values of format_mode
  localparam logic MODE_INTEGER = 1'b0;
  localparam logic MODE_WEIGHT  = 1'b1;

  // Character codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_POINT = 7'h2E;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_GRAM  = 7'h67;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_SHIFT,
    CONV_DONE
  } conv_state_t;

  typedef enum logic [2:0] {
    EMIT_IDLE,
    EMIT_SIGN,
    EMIT_DIGITS,
    EMIT_SPACE,
    EMIT_GRAM
  } emit_state_t;

  // Handoff between the converter and the character sequencer
  typedef struct packed {
    logic done;
    logic neg;
  } conv_status_t;

  // Double-dabble correction of one BCD digit before it is shifted.
  function automatic logic [3:0] dabble_adjust(input logic [3:0] digit);
    logic [3:0] result;
    if (digit >= 4'd5) begin
      result = digit + 4'd3;
    end else begin
      result = digit;
    end
    return result;
  endfunction

endpackage

// ===== hw/rtl/sdaf_if.sv =====
// ----------------------------------------------------------------------------
// sdaf_if
// Valid/ready channels of the formatter: the number channel and the
// character channel.
// ----------------------------------------------------------------------------
interface sdaf_in_if #(
  parameter int VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdaf_out_if ();
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hw/rtl/sdaf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sdaf_cfg_regs
// APB-style register file holding the format mode.
// ----------------------------------------------------------------------------
module sdaf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sdaf_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [sdaf_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [sdaf_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output logic                               format_mode
);
  import sdaf_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_FORMAT_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= MODE_INTEGER;
    end else if (wr_en) begin
      format_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_FORMAT_MODE) begin
      prdata[0] = format_mode;
    end
  end

endmodule

// ===== hw/rtl/sdaf_dabble.sv =====
// ----------------------------------------------------------------------------
// sdaf_dabble
// Bit-serial binary to BCD converter. Takes the magnitude of a signed value
// and shifts it into a BCD register one bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sdaf_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS     = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         take,
  output logic                         idle,
  output sdaf_pkg::conv_status_t       status,
  output logic [4*DIGITS-1:0]          bcd
);
  import sdaf_pkg::*;

  localparam int CNT_BITS = $clog2(VALUE_BITS);

  conv_state_t           state, state_next;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [CNT_BITS-1:0]   cnt;
  logic [4*DIGITS-1:0]   bcd_adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = dabble_adjust(bcd[4*i +: 4]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CONV_IDLE: begin
        if (start) begin
          state_next = CONV_SHIFT;
        end
      end
      CONV_SHIFT: begin
        if (cnt == CNT_BITS'(VALUE_BITS - 1)) begin
          state_next = CONV_DONE;
        end
      end
      CONV_DONE: begin
        if (take) begin
          state_next = CONV_IDLE;
        end
      end
      default: state_next = CONV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == CONV_IDLE && start) begin
      // The most negative value negates to itself, which read as unsigned is
      // its true magnitude.
      neg <= value[VALUE_BITS-1];
      if (value[VALUE_BITS-1]) begin
        mag <= ~value + 1'b1;
      end else begin
        mag <= value;
      end
      bcd <= '0;
      cnt <= '0;
    end else if (state == CONV_SHIFT) begin
      bcd <= {bcd_adj[4*DIGITS-2:0], mag[VALUE_BITS-1]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

  assign idle        = (state == CONV_IDLE);
  assign status.done = (state == CONV_DONE);
  assign status.neg  = neg;

endmodule

// ===== hw/rtl/sdaf_emitter.sv =====
// ----------------------------------------------------------------------------
// sdaf_emitter
// Character sequencer. Shifts the BCD word out one digit per cycle unless
// stalled, drops leading zeros, inserts sign and, in weight mode, decimal
// point and gram suffix, and drives the registered character channel.
// ----------------------------------------------------------------------------
module sdaf_emitter #(
  parameter int DIGITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   format_mode,
  input  sdaf_pkg::conv_status_t status,
  input  logic [4*DIGITS-1:0]    bcd,
  output logic                   take,
  sdaf_out_if.source             out_ch
);
  import sdaf_pkg::*;

  localparam int CNT_BITS = $clog2(DIGITS + 1);

  emit_state_t         state, state_next;
  logic [4*DIGITS-1:0] sr, sr_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                neg, mode, started, started_next, dot, dot_next;
  logic                emit, emit_last;
  logic [6:0]          emit_char;
  logic                slot_free;
  logic [3:0]          top;
  logic [CNT_BITS-1:0] min_digits;
  logic                out_valid;
  logic [6:0]          out_char;
  logic                out_last;

  assign slot_free  = !out_valid || out_ch.ready;
  assign top        = sr[4*DIGITS-1 -: 4];
  assign min_digits = (mode == MODE_WEIGHT) ? CNT_BITS'(3) : CNT_BITS'(1);

  always_comb begin
    state_next   = state;
    sr_next      = sr;
    cnt_next     = cnt;
    started_next = started;
    dot_next     = dot;
    take         = 1'b0;
    emit         = 1'b0;
    emit_last    = 1'b0;
    emit_char    = CHAR_ZERO;
    case (state)
      EMIT_IDLE: begin
        if (status.done) begin
          take         = 1'b1;
          sr_next      = bcd;
          cnt_next     = CNT_BITS'(DIGITS);
          started_next = 1'b0;
          dot_next     = 1'b0;
          state_next   = EMIT_SIGN;
        end
      end
      EMIT_SIGN: begin
        if (!neg) begin
          state_next = EMIT_DIGITS;
        end else if (slot_free) begin
          emit       = 1'b1;
          emit_char  = CHAR_MINUS;
          state_next = EMIT_DIGITS;
        end
      end
      EMIT_DIGITS: begin
        if (mode == MODE_WEIGHT && cnt == CNT_BITS'(2) && !dot) begin
          // The last two digits are the hundredths.
          if (slot_free) begin
            emit      = 1'b1;
            emit_char = CHAR_POINT;
            dot_next  = 1'b1;
          end
        end else if (!started && top == 4'd0 && cnt > min_digits) begin
          sr_next  = {sr[4*DIGITS-5:0], 4'd0};
          cnt_next = cnt - 1'b1;
        end else if (slot_free) begin
          emit         = 1'b1;
          emit_char    = CHAR_ZERO + {3'd0, top};
          started_next = 1'b1;
          sr_next      = {sr[4*DIGITS-5:0], 4'd0};
          cnt_next     = cnt - 1'b1;
          if (cnt == CNT_BITS'(1)) begin
            if (mode == MODE_WEIGHT) begin
              state_next = EMIT_SPACE;
            end else begin
              emit_last  = 1'b1;
              state_next = EMIT_IDLE;
            end
          end
        end
      end
      EMIT_SPACE: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = CHAR_SPACE;
          state_next = EMIT_GRAM;
        end
      end
      EMIT_GRAM: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = CHAR_GRAM;
          emit_last  = 1'b1;
          state_next = EMIT_IDLE;
        end
      end
      default: state_next = EMIT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EMIT_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sr      <= sr_next;
    cnt     <= cnt_next;
    started <= started_next;
    dot     <= dot_next;
    if (take) begin
      neg  <= status.neg;
      mode <= format_mode;
    end
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.character = out_char;
  assign out_ch.last      = out_last;

endmodule

// ===== hw/rtl/signed_decimal_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter
// Formats signed numbers as decimal ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one signed VALUE_BITS-bit number per transaction. out_ch
//   returns its text one ASCII character per transaction, most significant
//   first, with last set on the final character. format_mode (register 0 of
//   the APB port) selects plain integer text or weight text "[-]W.FF g".
//   The mode is sampled when a converted number enters the sequencer, so the
//   user must write it only while the block is idle, which is not enforced.
// Operation:
//   After its acceptance a number goes through bit-serial double dabble over
//   all VALUE_BITS bits, a hand-off step and a sign step (spent for positive
//   numbers too), then a step for each BCD digit (leading zeros included) and
//   for each point or suffix character. The next number is converted while
//   the previous text is still being sent.
// Reset and stalls:
//   rst clears both sequencers, the output valid flag and format_mode, and
//   holds in_ch.ready low. When out_ch stalls the character register holds,
//   the sequencer waits, a finished conversion waits and in_ch.ready stays low.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter #(
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  sdaf_in_if.sink                            in_ch,
  sdaf_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sdaf_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [sdaf_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [sdaf_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import sdaf_pkg::*;

  // Enough BCD digits for a magnitude of 2**(VALUE_BITS-1).
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  logic                format_mode;
  logic                conv_idle;
  logic                take;
  conv_status_t        status;
  logic [4*DIGITS-1:0] bcd;

  assign in_ch.ready = conv_idle && !rst;

  sdaf_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .format_mode (format_mode)
  );

  sdaf_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (in_ch.valid),
    .value  (in_ch.value),
    .take   (take),
    .idle   (conv_idle),
    .status (status),
    .bcd    (bcd)
  );

  sdaf_emitter #(
    .DIGITS (DIGITS)
  ) u_emitter (
    .clk         (clk),
    .rst         (rst),
    .format_mode (format_mode),
    .status      (status),
    .bcd         (bcd),
    .take        (take),
    .out_ch      (out_ch)
  );

`ifndef SYNTHESIS
  // An accepted number occupies the converter for the following cycles.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while the converter was busy");

  // The sequencer only takes a finished conversion.
  a_take_when_done: assert property (@(posedge clk) disable iff (rst)
    take |-> status.done)
    else $error("sequencer took an unfinished conversion");

  // Every character sent is printable.
  a_printable: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.character >= CHAR_SPACE) && (out_ch.character <= 7'h7E))
    else $error("non-printable character sent");

  // A register write to format_mode lands on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr == REG_FORMAT_MODE) |=>
      format_mode == $past(pwdata[0]))
    else $error("format_mode write lost");
`endif

endmodule
